@@ rtl/core/sars_pkg.sv @@
package sars_pkg;
    localparam int TABLE_SIZE_DEF   = 16;
    localparam int SAMPLE_SLOTS_DEF = 10;
    localparam logic [9:0] PERIOD_RESET = 10'd10;
    localparam int RATE_W = 23;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOOK,
        ST_PKT,
        ST_RSTART,
        ST_RDIV,
        ST_RMUL,
        ST_RRD,
        ST_RACC,
        ST_RAVG,
        ST_RPAVG,
        ST_ROUT,
        ST_DIV
    } t_state;

    // request to the shared divider
    typedef struct packed {
        logic        go;
        logic [31:0] num;
        logic [15:0] den;
        logic        neg;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quo;
    } t_div_rsp;
endpackage

@@ rtl/core/sars_ram.sv @@
module sars_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/core/sars_div.sv @@
module sars_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sars_pkg::t_div_req i_req,
    output sars_pkg::t_div_rsp o_rsp
);
    logic [31:0] r_quo, n_quo;
    logic [31:0] r_rem, n_rem;
    logic [15:0] r_den;
    logic        r_neg;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy;
    logic        r_done;
    logic [32:0] w_trial;

    // restoring divide, one quotient bit per cycle
    always_comb begin
        w_trial = {r_rem, r_quo[31]} - {17'd0, r_den};
        n_rem   = w_trial[32] ? {r_rem[30:0], r_quo[31]} : w_trial[31:0];
        n_quo   = {r_quo[30:0], ~w_trial[32]};
        n_cnt   = r_cnt - 6'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
                r_quo  <= i_req.num;
                r_rem  <= 32'd0;
                r_den  <= i_req.den;
                r_neg  <= i_req.neg;
            end else if (r_busy) begin
                r_quo <= n_quo;
                r_rem <= n_rem;
                r_cnt <= n_cnt;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_neg ? (32'd0 - r_quo) : r_quo;
endmodule

@@ rtl/core/station_arrival_rate_stats_table_unit.sv @@
// Packet items (cmd 0) take a table search over the used entries, then an
// update. A report tick walks the entries; each costs four passes of the shared
// serial divider (period scale, rate, and the two averages) and a read and an
// accumulate step per stored sample read from the sample RAMs; a silent entry
// skips both and is emitted directly. busy is high throughout. Results come
// one per cycle-wide o_valid pulse and cannot be held off by the receiver.
module station_arrival_rate_stats_table_unit #(
    parameter int TABLE_SIZE   = sars_pkg::TABLE_SIZE_DEF,
    parameter int SAMPLE_SLOTS = sars_pkg::SAMPLE_SLOTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_cfg_we,
    input  logic [9:0]          i_cfg_wdata,
    input  logic                i_cmd,
    input  logic [15:0]         i_station_id,
    input  logic [7:0]          i_rcpi,
    input  logic signed [15:0]  i_rx_power,
    output logic                o_valid,
    output logic [15:0]         o_station_id_res,
    output logic [15:0]         o_packet_count,
    output logic [22:0]         o_rate_max,
    output logic [7:0]          o_rcpi_min,
    output logic [7:0]          o_rcpi_max,
    output logic [7:0]          o_rcpi_avg,
    output logic [7:0]          o_rcpi_last,
    output logic signed [15:0]  o_power_min,
    output logic signed [15:0]  o_power_max,
    output logic signed [15:0]  o_power_avg,
    output logic signed [15:0]  o_power_last,
    output logic                o_last
);
    localparam int EW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int CW = $clog2(TABLE_SIZE + 1);
    localparam int SW = (SAMPLE_SLOTS > 1) ? $clog2(SAMPLE_SLOTS) : 1;
    localparam int NW = $clog2(SAMPLE_SLOTS + 1);
    localparam int DEPTH = TABLE_SIZE * SAMPLE_SLOTS;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    sars_pkg::t_state r_state, n_state, r_ret, n_ret;

    logic [9:0]       r_period;
    logic [CW-1:0]    r_used;
    logic [15:0]      r_station [TABLE_SIZE];
    logic [15:0]      r_count   [TABLE_SIZE];
    logic [NW-1:0]    r_sidx    [TABLE_SIZE];
    logic [22:0]      r_rmax    [TABLE_SIZE];

    logic [EW-1:0]    r_e;
    logic [CW-1:0]    r_scan;
    logic [NW-1:0]    r_i;
    logic [15:0]      r_id;
    logic [7:0]       r_rc;
    logic [15:0]      r_pw;
    logic [15:0]      r_div;
    logic [31:0]      r_cnt100;
    logic [22:0]      r_rate;
    logic [NW-1:0]    r_n;
    logic [15:0]      r_rsum;
    logic [7:0]       r_rmn, r_rmx, r_rl, r_ravg;
    logic [15:0]      r_psum;
    logic signed [15:0] r_pmn, r_pmx, r_pl;
    logic             r_first;

    sars_pkg::t_div_req w_req;
    sars_pkg::t_div_rsp w_rsp;

    logic             w_we;
    logic [AW-1:0]    w_waddr, w_raddr;
    logic [7:0]       w_rc_rd;
    logic [15:0]      w_pw_rd;
    logic [EW-1:0]    w_scan_e;
    logic [9:0]       w_per;

    assign w_scan_e = r_scan[EW-1:0];
    assign w_per    = (r_period == 10'd0) ? 10'd1 : r_period;

    sars_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    sars_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_rc_ram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(r_rc),
        .i_raddr(w_raddr), .o_rdata(w_rc_rd)
    );

    sars_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_pw_ram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(r_pw),
        .i_raddr(w_raddr), .o_rdata(w_pw_rd)
    );

    // ring slot of this packet, wrapping at the ring size
    logic [NW-1:0] w_slot;
    assign w_slot  = (r_sidx[r_e] >= NW'(SAMPLE_SLOTS)) ? '0 : r_sidx[r_e];
    assign w_we    = (r_state == sars_pkg::ST_PKT);
    assign w_waddr = AW'(r_e * SAMPLE_SLOTS + w_slot);
    assign w_raddr = AW'(r_e * SAMPLE_SLOTS + r_i);

    // sequencer
    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        w_req   = '0;
        unique case (r_state)
            sars_pkg::ST_IDLE: begin
                if (start) begin
                    n_state = i_cmd ? sars_pkg::ST_RSTART : sars_pkg::ST_LOOK;
                end
            end
            sars_pkg::ST_LOOK: begin
                if (r_scan == r_used) begin
                    n_state = (r_used == CW'(TABLE_SIZE)) ? sars_pkg::ST_IDLE
                                                          : sars_pkg::ST_PKT;
                end else if (r_station[w_scan_e] == r_id) begin
                    n_state = sars_pkg::ST_PKT;
                end
            end
            sars_pkg::ST_PKT: n_state = sars_pkg::ST_IDLE;
            sars_pkg::ST_RSTART: begin
                if (r_scan == r_used) begin
                    n_state = sars_pkg::ST_IDLE;
                end else if (r_count[w_scan_e] == 16'd0) begin
                    n_state = sars_pkg::ST_ROUT;
                end else begin
                    w_req.go  = 1'b1;
                    w_req.num = 32'd1000;
                    w_req.den = {6'd0, w_per};
                    n_state   = sars_pkg::ST_DIV;
                    n_ret     = sars_pkg::ST_RDIV;
                end
            end
            sars_pkg::ST_RDIV: begin
                w_req.go  = 1'b1;
                w_req.num = r_cnt100;
                w_req.den = r_div;
                n_state   = sars_pkg::ST_DIV;
                n_ret     = sars_pkg::ST_RMUL;
            end
            sars_pkg::ST_RMUL: begin
                n_state = (r_n == '0) ? sars_pkg::ST_ROUT : sars_pkg::ST_RRD;
            end
            sars_pkg::ST_RRD: n_state = sars_pkg::ST_RACC;
            sars_pkg::ST_RACC: begin
                n_state = (r_i == r_n) ? sars_pkg::ST_RAVG : sars_pkg::ST_RRD;
            end
            sars_pkg::ST_RAVG: begin
                w_req.go  = 1'b1;
                w_req.num = {16'd0, r_rsum};
                w_req.den = 16'(r_n);
                n_state   = sars_pkg::ST_DIV;
                n_ret     = sars_pkg::ST_RPAVG;
            end
            sars_pkg::ST_RPAVG: begin
                w_req.go  = 1'b1;
                w_req.num = r_psum[15] ? {16'd0, 16'd0 - r_psum} : {16'd0, r_psum};
                w_req.den = 16'(r_n);
                w_req.neg = r_psum[15];
                n_state   = sars_pkg::ST_DIV;
                n_ret     = sars_pkg::ST_ROUT;
            end
            sars_pkg::ST_ROUT: n_state = sars_pkg::ST_RSTART;
            sars_pkg::ST_DIV: begin
                if (w_rsp.done) begin
                    n_state = r_ret;
                end
            end
            default: n_state = sars_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sars_pkg::ST_IDLE;
            r_ret   <= sars_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= sars_pkg::PERIOD_RESET;
            r_used   <= '0;
            o_valid  <= 1'b0;
            for (int k = 0; k < TABLE_SIZE; k++) begin
                r_rmax[k] <= '0;
            end
        end else begin
            o_valid <= 1'b0;
            if (i_cfg_we) begin
                r_period <= i_cfg_wdata;
            end
            unique case (r_state)
                sars_pkg::ST_IDLE: begin
                    r_scan <= '0;
                    r_id   <= i_station_id;
                    r_rc   <= i_rcpi;
                    r_pw   <= i_rx_power;
                end
                sars_pkg::ST_LOOK: begin
                    if (r_scan == r_used) begin
                        if (r_used != CW'(TABLE_SIZE)) begin
                            r_e                <= w_scan_e;
                            r_station[w_scan_e] <= r_id;
                            r_count[w_scan_e]  <= '0;
                            r_sidx[w_scan_e]   <= '0;
                            r_rmax[w_scan_e]   <= '0;
                            r_used             <= r_used + CW'(1);
                        end
                    end else if (r_station[w_scan_e] == r_id) begin
                        r_e <= w_scan_e;
                    end else begin
                        r_scan <= r_scan + CW'(1);
                    end
                end
                sars_pkg::ST_PKT: begin
                    r_sidx[r_e] <= w_slot + NW'(1);
                    if (r_count[r_e] != 16'hFFFF) begin
                        r_count[r_e] <= r_count[r_e] + 16'd1;
                    end
                end
                sars_pkg::ST_RSTART: begin
                    r_e      <= w_scan_e;
                    r_cnt100 <= 32'(r_count[w_scan_e]) * 32'd100;
                    r_n      <= (r_sidx[w_scan_e] > NW'(SAMPLE_SLOTS)) ?
                                NW'(SAMPLE_SLOTS) : r_sidx[w_scan_e];
                    r_i      <= '0;
                    r_first  <= 1'b1;
                    r_rsum   <= '0;
                    r_psum   <= '0;
                    {r_rmn, r_rmx, r_rl, r_ravg} <= '0;
                    {r_pmn, r_pmx, r_pl} <= '0;
                end
                sars_pkg::ST_DIV: begin
                    if (w_rsp.done) begin
                        unique case (r_ret)
                            sars_pkg::ST_RDIV:
                                r_div <= (w_rsp.quo == 32'd0) ? 16'd1 : w_rsp.quo[15:0];
                            sars_pkg::ST_RMUL: r_rate <= w_rsp.quo[22:0];
                            sars_pkg::ST_RPAVG: r_ravg <= w_rsp.quo[7:0];
                            sars_pkg::ST_ROUT: r_psum <= w_rsp.quo[15:0];
                            default: ;
                        endcase
                    end
                end
                sars_pkg::ST_RMUL: begin
                    if (r_rate > r_rmax[r_e]) begin
                        r_rmax[r_e] <= r_rate;
                    end
                end
                sars_pkg::ST_RRD: r_i <= r_i + NW'(1);
                sars_pkg::ST_RACC: begin
                    r_rsum  <= r_rsum + 16'(w_rc_rd);
                    r_psum  <= r_psum + w_pw_rd;
                    r_rl    <= w_rc_rd;
                    r_pl    <= w_pw_rd;
                    r_first <= 1'b0;
                    if (r_first || w_rc_rd < r_rmn) r_rmn <= w_rc_rd;
                    if (r_first || w_rc_rd > r_rmx) r_rmx <= w_rc_rd;
                    if (r_first || $signed(w_pw_rd) < r_pmn) r_pmn <= w_pw_rd;
                    if (r_first || $signed(w_pw_rd) > r_pmx) r_pmx <= w_pw_rd;
                end
                sars_pkg::ST_ROUT: begin
                    // emit one transfer, then clear interval state
                    o_valid          <= 1'b1;
                    o_station_id_res <= r_station[r_e];
                    o_last           <= (r_scan + CW'(1) == r_used);
                    if (r_count[r_e] == 16'd0) begin
                        r_rmax[r_e]    <= '0;
                        o_packet_count <= '0;
                        o_rate_max     <= '0;
                        {o_rcpi_min, o_rcpi_max, o_rcpi_avg, o_rcpi_last} <= '0;
                        {o_power_min, o_power_max, o_power_avg, o_power_last} <= '0;
                    end else begin
                        o_packet_count <= r_count[r_e];
                        o_rate_max     <= r_rmax[r_e];
                        o_rcpi_min     <= r_rmn;
                        o_rcpi_max     <= r_rmx;
                        o_rcpi_avg     <= (r_n == '0) ? 8'd0 : r_ravg;
                        o_rcpi_last    <= r_rl;
                        o_power_min    <= r_pmn;
                        o_power_max    <= r_pmx;
                        o_power_avg    <= (r_n == '0) ? 16'sd0 : r_psum;
                        o_power_last   <= r_pl;
                    end
                    r_count[r_e] <= '0;
                    r_sidx[r_e]  <= '0;
                    r_scan       <= r_scan + CW'(1);
                end
                default: ;
            endcase
        end
    end

    // busy whenever the sequencer is working on an item
    always_comb begin
        busy = (r_state != sars_pkg::ST_IDLE);
    end

    // table never exceeds its size
    a_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CW'(TABLE_SIZE)) else $error("table overfilled");
    // a result only leaves during a report walk
    a_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == sars_pkg::ST_ROUT)) else $error("stray result");
    // every divider start moves the sequencer into its divider wait state
    a_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.go |=> r_state == sars_pkg::ST_DIV) else $error("divider lost");
endmodule
